// File: rtl/core/lpht_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the linear-probe hash table.
// No dependencies; every other file in rtl/core but lpht_ram imports this package.
package lpht_pkg;

  localparam int MIN_SIZE_LOG = 4;
  localparam int MAX_SIZE_LOG = 10;
  localparam int ITEM_BITS    = 64;

  localparam int IDX_W  = MAX_SIZE_LOG;
  localparam int ADDR_W = MAX_SIZE_LOG + 1;
  localparam int CNT_W  = MAX_SIZE_LOG + 1;
  localparam int LG_W   = $clog2(MAX_SIZE_LOG + 1);

  typedef enum logic [2:0] {
    OP_GET     = 3'd0,
    OP_PUT     = 3'd1,
    OP_REPLACE = 3'd2,
    OP_ADD     = 3'd3,
    OP_REMOVE  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    HIT_LIVE,
    HIT_TOMB,
    HIT_FREE,
    HIT_NONE
  } hit_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PROBE,
    ST_RH_CLEAR,
    ST_RH_READ,
    ST_RH_SRC,
    ST_RH_PROBE,
    ST_RH_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] item_in;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [63:0]      old_item;
    logic             add_done;
    logic [CNT_W-1:0] live_count;
    logic             status;
  } rsp_t;

  typedef struct packed {
    logic                 occ;
    logic                 live;
    logic [63:0]          key_high;
    logic [63:0]          key_low;
    logic [ITEM_BITS-1:0] item;
  } slot_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    slot_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [CNT_W-1:0] size_of(input logic [LG_W-1:0] lg);
    return CNT_W'(1) << lg;
  endfunction

  function automatic logic [CNT_W-1:0] thr_of(input logic [LG_W-1:0] lg);
    logic [CNT_W-1:0] s;
    s = size_of(lg);
    return s - (s >> 2);
  endfunction

  function automatic logic [IDX_W-1:0] mask_of(input logic [LG_W-1:0] lg);
    logic [CNT_W-1:0] m;
    m = size_of(lg) - CNT_W'(1);
    return m[IDX_W-1:0];
  endfunction

endpackage

// File: rtl/core/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// Linear-probe hash table: 128-bit keys, tombstones, two banks for rehash.
// Depends on lpht_pkg, lpht_ram and lpht_ctrl.
//
// Usage: present a request on req_i and raise start; it is taken at a clock
// edge where start is high and busy is low. Exactly one response follows on
// rsp_o, marked by done_o for a single cycle; the receiver must take it then.
// Timing: one slot is examined per cycle, since the slot RAM has one read
// port with registered data. busy drops in the same cycle that done_o rises,
// so the next request can follow.
// An insert that crosses three quarters occupancy first rehashes: a clear
// sweep of the new table size, a scan that reads each old slot and probes
// the new bank for each live entry, a switch of banks, then the claim is
// probed again.
// Reset: the control state returns to an empty table of minimum size, then a
// clearing pass wipes all 2048 slots of the RAM; busy stays high meanwhile.
module linear_probe_hash_table_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  lpht_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output lpht_pkg::rsp_t rsp_o
);
  import lpht_pkg::*;

  ram_req_t ram_req;
  slot_t    rdata;

  lpht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .busy    (busy),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .ram_o   (ram_req),
    .rdata_i (rdata)
  );

  lpht_ram #(
    .DW ($bits(slot_t)),
    .AW (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

endmodule

// File: rtl/core/lpht_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module lpht_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/lpht_cmp.sv
`timescale 1ns / 1ps
// Slot compare unit: classifies one slot against a 128-bit key.
// Depends on lpht_pkg; shared by request probes and rehash probes.
module lpht_cmp (
  input  lpht_pkg::slot_t slot_i,
  input  logic [63:0]     key_high_i,
  input  logic [63:0]     key_low_i,
  output lpht_pkg::hit_e  kind_o
);
  import lpht_pkg::*;

  always_comb begin
    if (!slot_i.occ) begin
      kind_o = HIT_FREE;
    end else if (slot_i.key_high == key_high_i && slot_i.key_low == key_low_i) begin
      kind_o = slot_i.live ? HIT_LIVE : HIT_TOMB;
    end else begin
      kind_o = HIT_NONE;
    end
  end

endmodule

// File: rtl/core/lpht_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: probes, updates, table rehash and power-up clearing pass.
// Depends on lpht_pkg and lpht_cmp; drives the slot RAM through ram_req_t.
module lpht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  lpht_pkg::req_t    req_i,
  output logic              busy,
  output logic              done_o,
  output lpht_pkg::rsp_t    rsp_o,
  output lpht_pkg::ram_req_t ram_o,
  input  lpht_pkg::slot_t   rdata_i
);
  import lpht_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic              bank_q, bank_d;
  logic [LG_W-1:0]   lg_q, lg_d;
  logic [LG_W-1:0]   new_lg_q, new_lg_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              retry_q, retry_d;
  slot_t             mv_q, mv_d;
  rsp_t              rsp_q, rsp_d;
  logic              done_q, done_d;

  hit_e              kind;
  logic [63:0]       cmp_kh, cmp_kl;
  logic [IDX_W-1:0]  m_cur, m_new;
  slot_t             new_slot;
  logic              fin;
  logic [CNT_W+2:0]  n_ext, s_ext;

  assign m_cur = mask_of(lg_q);
  assign m_new = mask_of(new_lg_q);
  assign cmp_kh = (state_q == ST_RH_PROBE) ? mv_q.key_high : req_q.key_high;
  assign cmp_kl = (state_q == ST_RH_PROBE) ? mv_q.key_low : req_q.key_low;

  lpht_cmp u_cmp (
    .slot_i     (rdata_i),
    .key_high_i (cmp_kh),
    .key_low_i  (cmp_kl),
    .kind_o     (kind)
  );

  always_comb begin
    new_slot.occ      = 1'b1;
    new_slot.live     = 1'b1;
    new_slot.key_high = req_q.key_high;
    new_slot.key_low  = req_q.key_low;
    new_slot.item     = req_q.item_in[ITEM_BITS-1:0];
  end

  assign n_ext = (CNT_W+3)'(total_q) + (CNT_W+3)'(1);
  assign s_ext = (CNT_W+3)'(size_of(lg_q));

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    bank_d   = bank_q;
    lg_d     = lg_q;
    new_lg_d = new_lg_q;
    occ_d    = occ_q;
    total_d  = total_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    scan_d   = scan_q;
    clr_d    = clr_q;
    retry_d  = retry_q;
    mv_d     = mv_q;
    rsp_d    = rsp_q;
    done_d   = 1'b0;
    fin      = 1'b0;
    ram_o    = '0;

    unique case (state_q)
      ST_INIT: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = clr_q;
        clr_d       = clr_q + ADDR_W'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          req_d       = req_i;
          idx_d       = req_i.key_low[IDX_W-1:0] & m_cur;
          cnt_d       = '0;
          retry_d     = 1'b0;
          ram_o.re    = 1'b1;
          ram_o.raddr = {bank_q, idx_d};
          state_d     = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (kind == HIT_NONE && cnt_q != m_cur) begin
          // advance to the next slot, wrapping inside the table
          idx_d       = (idx_q + IDX_W'(1)) & m_cur;
          cnt_d       = cnt_q + IDX_W'(1);
          ram_o.re    = 1'b1;
          ram_o.raddr = {bank_q, idx_d};
        end else begin
          ram_o.waddr    = {bank_q, idx_q};
          rsp_d          = '0;
          if (retry_q) begin
            fin = 1'b1;
            if (kind == HIT_FREE) begin
              ram_o.we       = 1'b1;
              ram_o.wdata    = new_slot;
              occ_d          = occ_q + CNT_W'(1);
              total_d        = total_q + CNT_W'(1);
              rsp_d.add_done = (req_q.opcode == OP_ADD);
            end else begin
              rsp_d.status = 1'b1;
            end
          end else begin
            rsp_d.found    = (kind == HIT_LIVE);
            rsp_d.old_item = (kind == HIT_LIVE) ? 64'(rdata_i.item) : 64'd0;
            fin            = 1'b1;
            case (req_q.opcode)
              OP_PUT, OP_ADD: begin
                if (kind == HIT_LIVE) begin
                  if (req_q.opcode == OP_PUT) begin
                    ram_o.we         = 1'b1;
                    ram_o.wdata      = rdata_i;
                    ram_o.wdata.item = req_q.item_in[ITEM_BITS-1:0];
                  end
                end else if (kind == HIT_TOMB) begin
                  // revive the tombstone in place
                  ram_o.we         = 1'b1;
                  ram_o.wdata      = rdata_i;
                  ram_o.wdata.live = 1'b1;
                  ram_o.wdata.item = req_q.item_in[ITEM_BITS-1:0];
                  total_d          = total_q + CNT_W'(1);
                  rsp_d.add_done   = (req_q.opcode == OP_ADD);
                end else if (kind == HIT_FREE &&
                             ({1'b0, occ_q} + (CNT_W+1)'(1)) < {1'b0, thr_of(lg_q)}) begin
                  ram_o.we       = 1'b1;
                  ram_o.wdata    = new_slot;
                  occ_d          = occ_q + CNT_W'(1);
                  total_d        = total_q + CNT_W'(1);
                  rsp_d.add_done = (req_q.opcode == OP_ADD);
                end else if (lg_q >= LG_W'(MAX_SIZE_LOG) &&
                             n_ext >= (CNT_W+3)'(thr_of(LG_W'(MAX_SIZE_LOG)))) begin
                  rsp_d.status = 1'b1;
                end else begin
                  // rehash into the other bank, then retry the claim
                  fin      = 1'b0;
                  new_lg_d = lg_q;
                  if ((n_ext << 1) > s_ext) begin
                    if (lg_q < LG_W'(MAX_SIZE_LOG)) begin
                      new_lg_d = lg_q + LG_W'(1);
                    end
                  end else if ((n_ext << 2) < s_ext) begin
                    if (lg_q > LG_W'(MIN_SIZE_LOG)) begin
                      new_lg_d = lg_q - LG_W'(1);
                    end
                  end
                  cnt_d   = '0;
                  state_d = ST_RH_CLEAR;
                end
              end
              OP_REPLACE: begin
                if (kind == HIT_LIVE) begin
                  ram_o.we         = 1'b1;
                  ram_o.wdata      = rdata_i;
                  ram_o.wdata.item = req_q.item_in[ITEM_BITS-1:0];
                end
              end
              OP_REMOVE: begin
                if (kind == HIT_LIVE) begin
                  ram_o.we         = 1'b1;
                  ram_o.wdata      = rdata_i;
                  ram_o.wdata.live = 1'b0;
                  total_d          = total_q - CNT_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      ST_RH_CLEAR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = {~bank_q, cnt_q};
        cnt_d       = cnt_q + IDX_W'(1);
        if (cnt_q == m_new) begin
          scan_d  = '0;
          state_d = ST_RH_READ;
        end
      end

      ST_RH_READ: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = {bank_q, scan_q};
        state_d     = ST_RH_SRC;
      end

      ST_RH_SRC: begin
        if (rdata_i.occ && rdata_i.live) begin
          mv_d        = rdata_i;
          idx_d       = rdata_i.key_low[IDX_W-1:0] & m_new;
          cnt_d       = '0;
          ram_o.re    = 1'b1;
          ram_o.raddr = {~bank_q, idx_d};
          state_d     = ST_RH_PROBE;
        end else begin
          scan_d  = scan_q + IDX_W'(1);
          state_d = (scan_q == m_cur) ? ST_RH_FIN : ST_RH_READ;
        end
      end

      ST_RH_PROBE: begin
        if (kind == HIT_NONE && cnt_q != m_new) begin
          idx_d       = (idx_q + IDX_W'(1)) & m_new;
          cnt_d       = cnt_q + IDX_W'(1);
          ram_o.re    = 1'b1;
          ram_o.raddr = {~bank_q, idx_d};
        end else begin
          if (kind == HIT_FREE) begin
            ram_o.we    = 1'b1;
            ram_o.waddr = {~bank_q, idx_q};
            ram_o.wdata = mv_q;
          end
          scan_d  = scan_q + IDX_W'(1);
          state_d = (scan_q == m_cur) ? ST_RH_FIN : ST_RH_READ;
        end
      end

      ST_RH_FIN: begin
        bank_d      = ~bank_q;
        lg_d        = new_lg_q;
        occ_d       = total_q;
        retry_d     = 1'b1;
        idx_d       = req_q.key_low[IDX_W-1:0] & m_new;
        cnt_d       = '0;
        ram_o.re    = 1'b1;
        ram_o.raddr = {~bank_q, idx_d};
        state_d     = ST_PROBE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      rsp_d.live_count = total_d;
      done_d           = 1'b1;
      state_d          = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      bank_q   <= 1'b0;
      lg_q     <= LG_W'(MIN_SIZE_LOG);
      new_lg_q <= LG_W'(MIN_SIZE_LOG);
      occ_q    <= '0;
      total_q  <= '0;
      clr_q    <= '0;
      retry_q  <= 1'b0;
      done_q   <= 1'b0;
      idx_q    <= '0;
      cnt_q    <= '0;
      scan_q   <= '0;
    end else begin
      state_q  <= state_d;
      bank_q   <= bank_d;
      lg_q     <= lg_d;
      new_lg_q <= new_lg_d;
      occ_q    <= occ_d;
      total_q  <= total_d;
      clr_q    <= clr_d;
      retry_q  <= retry_d;
      done_q   <= done_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      scan_q   <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    mv_q  <= mv_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: rtl/core/lpht_chk.sv
`timescale 1ns / 1ps
// Port-level checker for linear_probe_hash_table_unit, attached by bind.
// Depends on lpht_pkg.
module lpht_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input lpht_pkg::rsp_t rsp_o
);
  import lpht_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("response strobe lasted more than one cycle");

  a_refused_no_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status |-> !rsp_o.add_done && !rsp_o.found)
    else $error("refused insert reported success or a hit");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.found |-> rsp_o.old_item == 64'd0)
    else $error("miss returned a nonzero item");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.live_count <= size_of(LG_W'(MAX_SIZE_LOG)))
    else $error("live count beyond table capacity");

endmodule

bind linear_probe_hash_table_unit lpht_chk u_lpht_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
